>>> rtl/core/s2lab_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time functions for the sRGB to CIELAB converter.
// Depends on nothing; every other file of the block but s2lab_cdiv refers to it by scoped names.
package s2lab_pkg;

  localparam int CHANNEL_BITS_DEF  = 8;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int Q_FRAC      = 30;
  localparam int Q_W         = 31;
  localparam int LIN_ENTRIES = 256;

  localparam longint unsigned MX_R = 4124;
  localparam longint unsigned MX_G = 3576;
  localparam longint unsigned MX_B = 1805;
  localparam longint unsigned MY_R = 2126;
  localparam longint unsigned MY_G = 7152;
  localparam longint unsigned MY_B = 722;
  localparam longint unsigned MZ_R = 193;
  localparam longint unsigned MZ_G = 1192;
  localparam longint unsigned MZ_B = 9505;
  localparam longint unsigned X_DEN = 95047;
  localparam longint unsigned Y_DEN = 10000;
  localparam longint unsigned Z_DEN = 108883;

  localparam int PROD_W = 45;
  localparam int XZ_NUM_W = 47;
  localparam int Y_NUM_W  = 44;

  localparam longint unsigned LAB_THRESH = (64'd8856 << Q_FRAC) / 64'd1000000;
  localparam longint unsigned LAB_OFFSET = (64'd16 << Q_FRAC) / 64'd116;
  localparam longint unsigned LIN_GAIN   = 7787;
  localparam longint unsigned LIN_DEN    = 1000;
  localparam int LNUM_W = 37;
  localparam int LQ_W   = 27;

  localparam int RAW_W = 42;

  localparam int CDIV_LAT   = 4;
  localparam int MATRIX_LAT = 2 + CDIV_LAT;
  localparam int LABF_LAT   = 2 * Q_W + 1;
  localparam int OUT_LAT    = 2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic        [14:0] lightness;
    logic signed [15:0] green_red;
    logic signed [15:0] blue_yellow;
  } lab_t;

  typedef logic [LIN_ENTRIES-1:0][Q_W-1:0] lin_table_t;

  function automatic longint unsigned mulq(input longint unsigned a,
                                           input longint unsigned b);
    return (a * b) >> Q_FRAC;
  endfunction

  function automatic longint unsigned pow5q(input longint unsigned r);
    longint unsigned p;
    p = mulq(r, r);
    p = mulq(p, r);
    p = mulq(p, r);
    return mulq(p, r);
  endfunction

  function automatic longint unsigned root5q(input longint unsigned u);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'd1 << Q_FRAC;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 1) >> 1);
      if (pow5q(mid) <= u) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo;
  endfunction

  // Restoring long division, used only while the gamma table is built.
  function automatic longint unsigned long_div(input longint unsigned n,
                                               input longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 1) | ((n >> i) & 64'd1);
      if (rem >= d) begin
        rem = rem - d;
        q   = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  function automatic longint unsigned linearize(input longint unsigned n, input int cb);
    longint unsigned d;
    longint unsigned t;
    longint unsigned u;
    d = (64'd1 << cb) - 1;
    if (100000 * n <= 4045 * d) begin
      return long_div((n * 100) << Q_FRAC, 1292 * d);
    end
    t = long_div((1000 * n + 55 * d) << Q_FRAC, 1055 * d);
    u = mulq(t, t);
    return mulq(u, root5q(u));
  endfunction

  function automatic lin_table_t build_lin_table(input int cb);
    lin_table_t tbl;
    longint unsigned v;
    for (int i = 0; i < LIN_ENTRIES; i++) begin
      v = linearize(longint'(i), cb);
      tbl[i] = v[Q_W-1:0];
    end
    return tbl;
  endfunction

endpackage

>>> rtl/core/s2lab_rgb_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one sRGB pixel per transaction.
// Depends on s2lab_pkg for the payload type.
interface s2lab_rgb_if;
  logic              valid;
  logic              ready;
  s2lab_pkg::rgb_t   data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/core/s2lab_lab_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one CIELAB result per transaction.
// Depends on s2lab_pkg for the payload type.
interface s2lab_lab_if;
  logic              valid;
  logic              ready;
  s2lab_pkg::lab_t   data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/core/s2lab_cdiv.sv
`timescale 1ns / 1ps
// Four-stage divider by a fixed constant: reciprocal multiplication and one correction step.
// Depends on nothing beyond its parameters.
module s2lab_cdiv #(
  parameter int              NUM_W = 47,
  parameter int              QUO_W = 31,
  parameter longint unsigned DEN   = 95047
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  output logic [QUO_W-1:0] quo
);

  localparam int              MW    = NUM_W - $clog2(DEN) + 1;
  localparam int              LO_W  = NUM_W / 2;
  localparam int              HI_W  = NUM_W - LO_W;
  localparam int              SUM_W = NUM_W + MW;
  localparam longint unsigned RECIP = (64'd1 << NUM_W) / DEN;
  localparam logic [MW-1:0]   M     = MW'(RECIP);

  logic [LO_W+MW-1:0] p_lo;
  logic [HI_W+MW-1:0] p_hi;
  logic [NUM_W-1:0]   n1, n2, n3;
  logic [SUM_W-1:0]   sum;
  logic [QUO_W-1:0]   q0, q3;
  logic [NUM_W-1:0]   qd;
  logic [NUM_W-1:0]   rem;
  logic               fix;

  // The estimate never exceeds the true quotient and falls short of it by at most one.
  always_ff @(posedge clk) begin
    if (en) begin
      p_lo <= (LO_W+MW)'(num[LO_W-1:0]) * (LO_W+MW)'(M);
      p_hi <= (HI_W+MW)'(num[NUM_W-1:LO_W]) * (HI_W+MW)'(M);
      n1   <= num;
    end
  end

  assign sum = (SUM_W'(p_hi) << LO_W) + SUM_W'(p_lo);

  always_ff @(posedge clk) begin
    if (en) begin
      q0 <= sum[NUM_W+QUO_W-1:NUM_W];
      n2 <= n1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qd <= NUM_W'(q0) * NUM_W'(DEN);
      q3 <= q0;
      n3 <= n2;
    end
  end

  assign rem = n3 - qd;
  assign fix = rem >= NUM_W'(DEN);

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= q3 + QUO_W'(fix);
    end
  end

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(rem) |-> rem < NUM_W'(2 * DEN))
    else $error("reciprocal estimate was off by more than one");

endmodule

>>> rtl/core/s2lab_matrix.sv
`timescale 1ns / 1ps
// Linear RGB to XYZ matrix with white point normalisation by constant dividers.
// Depends on s2lab_pkg and s2lab_cdiv.
module s2lab_matrix (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [s2lab_pkg::Q_W-1:0]  r,
  input  logic [s2lab_pkg::Q_W-1:0]  g,
  input  logic [s2lab_pkg::Q_W-1:0]  b,
  output logic [s2lab_pkg::Q_W-1:0]  x,
  output logic [s2lab_pkg::Q_W-1:0]  y,
  output logic [s2lab_pkg::Q_W-1:0]  z
);

  localparam int PW = s2lab_pkg::PROD_W;
  localparam int NX = s2lab_pkg::XZ_NUM_W;
  localparam int NY = s2lab_pkg::Y_NUM_W;

  logic [PW-1:0] xr, xg, xb, yr, yg, yb, zr, zg, zb;
  logic [NX-1:0] sx, sz;
  logic [NX-1:0] nx, nz;
  logic [NY-1:0] ny;

  always_ff @(posedge clk) begin
    if (en) begin
      xr <= PW'(r) * PW'(s2lab_pkg::MX_R);
      xg <= PW'(g) * PW'(s2lab_pkg::MX_G);
      xb <= PW'(b) * PW'(s2lab_pkg::MX_B);
      yr <= PW'(r) * PW'(s2lab_pkg::MY_R);
      yg <= PW'(g) * PW'(s2lab_pkg::MY_G);
      yb <= PW'(b) * PW'(s2lab_pkg::MY_B);
      zr <= PW'(r) * PW'(s2lab_pkg::MZ_R);
      zg <= PW'(g) * PW'(s2lab_pkg::MZ_G);
      zb <= PW'(b) * PW'(s2lab_pkg::MZ_B);
    end
  end

  assign sx = NX'(xr) + NX'(xg) + NX'(xb);
  assign sz = NX'(zr) + NX'(zg) + NX'(zb);

  always_ff @(posedge clk) begin
    if (en) begin
      nx <= (sx << 3) + (sx << 1);
      nz <= (sz << 3) + (sz << 1);
      ny <= NY'(yr) + NY'(yg) + NY'(yb);
    end
  end

  s2lab_cdiv #(.NUM_W(NX), .QUO_W(s2lab_pkg::Q_W), .DEN(s2lab_pkg::X_DEN)) u_div_x (
    .clk(clk), .rst(rst), .en(en), .num(nx), .quo(x)
  );
  s2lab_cdiv #(.NUM_W(NY), .QUO_W(s2lab_pkg::Q_W), .DEN(s2lab_pkg::Y_DEN)) u_div_y (
    .clk(clk), .rst(rst), .en(en), .num(ny), .quo(y)
  );
  s2lab_cdiv #(.NUM_W(NX), .QUO_W(s2lab_pkg::Q_W), .DEN(s2lab_pkg::Z_DEN)) u_div_z (
    .clk(clk), .rst(rst), .en(en), .num(nz), .quo(z)
  );

endmodule

>>> rtl/core/s2lab_cbrt.sv
`timescale 1ns / 1ps
// Pipelined bit-by-bit cube root in Q30, two register stages per result bit.
// Depends on s2lab_pkg.
module s2lab_cbrt #(
  parameter int W = s2lab_pkg::Q_W
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] v,
  output logic [W-1:0] c
);

  localparam int QF   = s2lab_pkg::Q_FRAC;
  localparam int SQ_W = 2 * W;
  localparam int P_W  = SQ_W - QF;
  localparam int PR_W = P_W + W;

  logic [W-1:0]    a_c   [W];
  logic [W-1:0]    a_ct  [W];
  logic [W-1:0]    a_v   [W];
  logic [SQ_W-1:0] a_sq  [W];
  logic [SQ_W-1:0] a_sqt [W];
  logic [PR_W-1:0] a_prod[W];
  logic [W-1:0]    b_c   [W];
  logic [W-1:0]    b_v   [W];
  logic [SQ_W-1:0] b_sq  [W];
  logic [W-1:0]    b_ct  [W-1];
  logic [SQ_W-1:0] b_sqt [W-1];

  for (genvar i = 0; i < W; i++) begin : g_bit
    localparam int K = W - 1 - i;
    logic [W-1:0]    c_in, ct_in, v_in, c_sel;
    logic [SQ_W-1:0] sq_in, sqt_in, sq_sel;
    logic            keep;

    if (i == 0) begin : g_first
      assign c_in   = '0;
      assign sq_in  = '0;
      assign ct_in  = W'(1) << K;
      assign sqt_in = SQ_W'(1) << (2 * K);
      assign v_in   = v;
    end else begin : g_next
      assign c_in   = b_c[i-1];
      assign sq_in  = b_sq[i-1];
      assign ct_in  = b_ct[i-1];
      assign sqt_in = b_sqt[i-1];
      assign v_in   = b_v[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_prod[i] <= PR_W'(sqt_in[SQ_W-1:QF]) * PR_W'(ct_in);
        a_c[i]    <= c_in;
        a_ct[i]   <= ct_in;
        a_sq[i]   <= sq_in;
        a_sqt[i]  <= sqt_in;
        a_v[i]    <= v_in;
      end
    end

    assign keep   = a_prod[i][PR_W-1:QF] <= (PR_W-QF)'(a_v[i]);
    assign c_sel  = keep ? a_ct[i] : a_c[i];
    assign sq_sel = keep ? a_sqt[i] : a_sq[i];

    always_ff @(posedge clk) begin
      if (en) begin
        b_c[i]  <= c_sel;
        b_sq[i] <= sq_sel;
        b_v[i]  <= a_v[i];
      end
    end

    if (K > 0) begin : g_trial
      always_ff @(posedge clk) begin
        if (en) begin
          b_ct[i]  <= c_sel | (W'(1) << (K - 1));
          b_sqt[i] <= sq_sel + (SQ_W'(c_sel) << K) + (SQ_W'(1) << (2 * K - 2));
        end
      end
    end
  end

  assign c = b_c[W-1];

endmodule

>>> rtl/core/s2lab_labf.sv
`timescale 1ns / 1ps
// CIELAB companding function: cube root above the threshold, linear segment below.
// Depends on s2lab_pkg, s2lab_cbrt and s2lab_cdiv.
module s2lab_labf (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [s2lab_pkg::Q_W-1:0] v,
  output logic [s2lab_pkg::Q_W-1:0] f
);

  localparam int W        = s2lab_pkg::Q_W;
  localparam int LN       = s2lab_pkg::LNUM_W;
  localparam int LQ       = s2lab_pkg::LQ_W;
  localparam int CBRT_LAT = 2 * W;
  localparam int DLY      = CBRT_LAT - 1 - s2lab_pkg::CDIV_LAT;

  logic          big;
  logic [LN-1:0] lnum;
  logic [LQ-1:0] lq;
  logic [LQ-1:0] lq_dly [DLY];
  logic          big_dly[CBRT_LAT];
  logic [W-1:0]  root;

  assign big = 64'(v) > s2lab_pkg::LAB_THRESH;

  always_ff @(posedge clk) begin
    if (en) begin
      lnum <= big ? '0 : LN'(64'(v) * s2lab_pkg::LIN_GAIN);
    end
  end

  s2lab_cdiv #(.NUM_W(LN), .QUO_W(LQ), .DEN(s2lab_pkg::LIN_DEN)) u_div_lin (
    .clk(clk), .rst(rst), .en(en), .num(lnum), .quo(lq)
  );

  s2lab_cbrt #(.W(W)) u_cbrt (
    .clk(clk), .en(en), .v(v), .c(root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      lq_dly[0]  <= lq;
      big_dly[0] <= big;
      for (int j = 1; j < DLY; j++) begin
        lq_dly[j] <= lq_dly[j-1];
      end
      for (int j = 1; j < CBRT_LAT; j++) begin
        big_dly[j] <= big_dly[j-1];
      end
      f <= big_dly[CBRT_LAT-1] ? root
                               : W'(W'(lq_dly[DLY-1]) + W'(s2lab_pkg::LAB_OFFSET));
    end
  end

endmodule

>>> rtl/core/s2lab_out.sv
`timescale 1ns / 1ps
// Forms L, a and b from the companded values, rounds to the output format and saturates.
// Depends on s2lab_pkg; its last register is the output register of the block.
module s2lab_out #(
  parameter int FRACTION_BITS = s2lab_pkg::FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [s2lab_pkg::Q_W-1:0] fx,
  input  logic [s2lab_pkg::Q_W-1:0] fy,
  input  logic [s2lab_pkg::Q_W-1:0] fz,
  output s2lab_pkg::lab_t           data
);

  localparam int RW    = s2lab_pkg::RAW_W;
  localparam int SHIFT = s2lab_pkg::Q_FRAC - FRACTION_BITS;
  localparam logic signed [RW-1:0] HALF   = RW'(1) << (SHIFT - 1);
  localparam logic signed [RW-1:0] L_OFS  = RW'(16) << s2lab_pkg::Q_FRAC;
  localparam logic signed [RW-1:0] L_MAX  = RW'(100) << FRACTION_BITS;
  localparam logic signed [RW-1:0] AB_MAX = RW'(32767);
  localparam logic signed [RW-1:0] AB_MIN = -RW'(32768);

  logic signed [RW-1:0] sx, sy, sz;
  logic signed [RW-1:0] l_raw, a_raw, b_raw;
  logic signed [RW-1:0] l_rnd, a_rnd, b_rnd;
  logic signed [RW-1:0] l_sat, a_sat, b_sat;

  assign sx = $signed(RW'(fx));
  assign sy = $signed(RW'(fy));
  assign sz = $signed(RW'(fz));

  always_ff @(posedge clk) begin
    if (en) begin
      l_raw <= RW'(116) * sy - L_OFS;
      a_raw <= RW'(500) * (sx - sy);
      b_raw <= RW'(200) * (sy - sz);
    end
  end

  assign l_rnd = (l_raw + HALF) >>> SHIFT;
  assign a_rnd = (a_raw + HALF) >>> SHIFT;
  assign b_rnd = (b_raw + HALF) >>> SHIFT;

  always_comb begin
    l_sat = l_rnd;
    if (l_rnd < 0) begin
      l_sat = '0;
    end else if (l_rnd > L_MAX) begin
      l_sat = L_MAX;
    end
    a_sat = a_rnd;
    if (a_rnd < AB_MIN) begin
      a_sat = AB_MIN;
    end else if (a_rnd > AB_MAX) begin
      a_sat = AB_MAX;
    end
    b_sat = b_rnd;
    if (b_rnd < AB_MIN) begin
      b_sat = AB_MIN;
    end else if (b_rnd > AB_MAX) begin
      b_sat = AB_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data.lightness   <= l_sat[14:0];
      data.green_red   <= a_sat[15:0];
      data.blue_yellow <= b_sat[15:0];
    end
  end

endmodule

>>> rtl/core/srgb_to_cielab_pixel.sv
`timescale 1ns / 1ps
// A result passes 72 register stages (1 gamma table, 6 matrix and white point dividers,
// 63 companding, 2 output). Throughput: one pixel per cycle unless the output stalls.
// The depth is set by the cube root pipeline, two stages per result bit. A stalled
// output freezes the whole pipeline, so nothing is lost.
// Synchronous reset clears only the per-stage valid bits; data registers are not reset.
// Depends on s2lab_pkg, both channel interfaces, s2lab_matrix, s2lab_labf and s2lab_out.
module srgb_to_cielab_pixel #(
  parameter int CHANNEL_BITS  = s2lab_pkg::CHANNEL_BITS_DEF,
  parameter int FRACTION_BITS = s2lab_pkg::FRACTION_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  s2lab_rgb_if.sink    rgb,
  s2lab_lab_if.source  lab
);

  localparam s2lab_pkg::lin_table_t LIN_TABLE = s2lab_pkg::build_lin_table(CHANNEL_BITS);
  localparam int LAT = 1 + s2lab_pkg::MATRIX_LAT + s2lab_pkg::LABF_LAT + s2lab_pkg::OUT_LAT;
  localparam int W   = s2lab_pkg::Q_W;

  logic           en;
  logic [LAT-1:0] vld;
  logic [W-1:0]   lin_r, lin_g, lin_b;
  logic [W-1:0]   x, y, z;
  logic [W-1:0]   fx, fy, fz;

  assign en        = !vld[LAT-1] || lab.ready;
  assign rgb.ready = en;
  assign lab.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], rgb.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r <= LIN_TABLE[rgb.data.red];
      lin_g <= LIN_TABLE[rgb.data.green];
      lin_b <= LIN_TABLE[rgb.data.blue];
    end
  end

  s2lab_matrix u_matrix (
    .clk(clk), .rst(rst), .en(en),
    .r(lin_r), .g(lin_g), .b(lin_b),
    .x(x), .y(y), .z(z)
  );

  s2lab_labf u_labf_x (.clk(clk), .rst(rst), .en(en), .v(x), .f(fx));
  s2lab_labf u_labf_y (.clk(clk), .rst(rst), .en(en), .v(y), .f(fy));
  s2lab_labf u_labf_z (.clk(clk), .rst(rst), .en(en), .v(z), .f(fz));

  s2lab_out #(.FRACTION_BITS(FRACTION_BITS)) u_out (
    .clk(clk), .en(en), .fx(fx), .fy(fy), .fz(fz), .data(lab.data)
  );

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline advanced while the output was stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    rgb.valid && rgb.ready |=> vld[0])
    else $error("accepted transaction did not enter the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !lab.valid)
    else $error("result offered straight after reset");

endmodule
